// File: hdl/swm_pkg.sv
// Shared types for the sliding window median unit.
package swm_pkg;

	typedef logic signed [15:0] sample_t;

	typedef struct packed {
		sample_t val;
		sample_t cval;
		logic    lc;
		sample_t hist;
	} swm_link_t;

endpackage

// File: hdl/swm_cell.sv
// One cell of the sorted window: a sorted entry and one tap of the sample history.
module swm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              is_last,
	input  swm_pkg::sample_t  s,
	input  swm_pkg::sample_t  v_old,
	input  swm_pkg::swm_link_t left,
	input  swm_pkg::swm_link_t right,
	output swm_pkg::swm_link_t link
);
	import swm_pkg::*;

	sample_t val_q;
	sample_t hist_q;
	logic    gone;
	sample_t cval;
	logic    lc;
	sample_t val_d;

	// The oldest entry is the last one that holds the oldest sample's value.
	always_comb begin
		gone = ($signed(val_q) > $signed(v_old)) ||
			((val_q == v_old) && (is_last || (right.val != v_old)));
		cval = gone ? right.val : val_q;
		lc = !is_last && ($signed(cval) < $signed(s));
		if (lc) begin
			val_d = cval;
		end else if (left.lc) begin
			val_d = s;
		end else begin
			val_d = left.cval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= '0;
			hist_q <= '0;
		end else if (en) begin
			val_q  <= val_d;
			hist_q <= left.hist;
		end
	end

	assign link = '{val: val_q, cval: cval, lc: lc, hist: hist_q};

endmodule

// File: hdl/sliding_window_median_unit.sv
// Running median over a sliding window, built as a row of sorted-window cells.
//
// A request on the input channel (in_valid, in_ready, sample) carries one signed
// 16-bit sample. The block drops the oldest sample of the window, inserts the new
// one at its sorted place and presents the middle entry on the output channel
// (out_valid, out_ready, median). Every request gives exactly one result.
// Each cell holds one sorted entry and one tap of the sample history; all cells
// update together from their neighbors, so one sample per cycle is accepted while
// the receiver keeps up.
// The result appears the cycle after the request is accepted.
// The median is read straight from the middle cell, which doubles as the output
// register: while a result waits, in_ready is low, and it rises again in the
// cycle in which out_ready takes the pending result.
// Reset clears the window to zeros and leaves the output channel empty.
module sliding_window_median_unit #(
	parameter int WINDOW = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  swm_pkg::sample_t sample,
	output logic             out_valid,
	input  logic             out_ready,
	output swm_pkg::sample_t median
);
	import swm_pkg::*;

	localparam int MID = WINDOW / 2;

	swm_link_t links [WINDOW];
	logic      out_valid_q;
	logic      accept;
	swm_link_t head;
	swm_link_t tail;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign head = '{val: '0, cval: '0, lc: 1'b1, hist: sample};
	assign tail = '0;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		swm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (accept),
			.is_last (i == WINDOW - 1),
			.s       (sample),
			.v_old   (links[WINDOW-1].hist),
			.left    ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
			.right   ((i == WINDOW - 1) ? tail : links[(i == WINDOW - 1) ? i : i + 1]),
			.link    (links[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = links[MID].val;

endmodule

// File: hdl/swm_checker.sv
// Port-level assertions for the sliding window median unit and their binding.
module swm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input swm_pkg::sample_t median
);
	import swm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median))
		else $error("pending median changed before it was taken");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted request gave no result");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request accepted while a result is stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready while output is empty");

endmodule

bind sliding_window_median_unit swm_checker u_swm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.median    (median)
);

// File: sim/tb_sliding_window_median_unit.sv
// Self-checking testbench for the sliding window median unit: directed table, then random requests.
module tb_sliding_window_median_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import swm_pkg::*;

	localparam int WINDOW       = 31;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int PROBES       = 22;

	localparam sample_t PROBE_IN [PROBES] = '{
		32767, -32768, 1, -1, 21845, -21846, 7, 7, 7, 7, -7,
		-7, 32767, 32767, -32768, -32768, 0, 0, 100, -100, 256, -256
	};
	localparam bit PROBE_KNOWN [PROBES] = '{
		1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
	};
	localparam sample_t PROBE_MEDIAN [PROBES] = '{
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
	};

	logic    clk       = 1'b0;
	logic    arst_n    = 1'b0;
	logic    in_valid  = 1'b0;
	logic    in_ready;
	sample_t sample    = '0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	sample_t median;

	sample_t window_vals [WINDOW];
	int      window_ages [WINDOW];
	sample_t median_queue [$];
	sample_t oldest_median;
	sample_t last_sent   = '0;
	int      mismatches  = 0;
	int      idle_cycles = 0;
	bit      steady      = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sliding_window_median_unit #(
		.WINDOW(WINDOW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.median(median)
	);

	function automatic sample_t advance_window(input sample_t s);
		int i;
		int drop;
		int pos;
		drop = WINDOW - 1;
		for (i = 0; i < WINDOW; i++) begin
			if (window_ages[i] == WINDOW - 1) begin
				drop = i;
				break;
			end
		end
		for (i = drop; i < WINDOW - 1; i++) begin
			window_vals[i] = window_vals[i + 1];
			window_ages[i] = window_ages[i + 1];
		end
		for (i = 0; i < WINDOW - 1; i++) begin
			if (window_ages[i] < WINDOW - 1)
				window_ages[i] = window_ages[i] + 1;
		end
		pos = WINDOW - 1;
		for (i = 0; i < WINDOW - 1; i++) begin
			if (window_vals[i] >= s) begin
				pos = i;
				break;
			end
		end
		for (i = WINDOW - 1; i > pos; i--) begin
			window_vals[i] = window_vals[i - 1];
			window_ages[i] = window_ages[i - 1];
		end
		window_vals[pos] = s;
		window_ages[pos] = 0;
		return window_vals[WINDOW / 2];
	endfunction

	function automatic sample_t random_sample();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $signed(16'($urandom()));
			4, 5, 6: v = int'($urandom_range(0, 8)) - 4;
			7: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: begin
				v = int'(last_sent) + int'($urandom_range(0, 512)) - 256;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
			end
		endcase
		return sample_t'(v);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send_sample(input sample_t s, input bit known, input sample_t want);
		int gap;
		sample_t predicted;
		gap = steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!(in_valid && in_ready));
		predicted = advance_window(s);
		median_queue = {median_queue, known ? want : predicted};
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (median_queue.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		sample_t s;
		for (n = 0; n < WINDOW; n++) begin
			window_vals[n] = '0;
			window_ages[n] = n;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (n = 0; n < PROBES; n++)
			send_sample(PROBE_IN[n], PROBE_KNOWN[n], PROBE_MEDIAN[n]);
		drain_results();
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (n % 400 == 399)
				drain_results();
			s = random_sample();
			send_sample(s, 1'b0, '0);
			last_sent = s;
		end
		drain_results();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (median_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected median %0d", median));
			end else begin
				oldest_median = median_queue.pop_front();
				if (median !== oldest_median)
					report_mismatch($sformatf("median %0d, expected %0d", median, oldest_median));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

endmodule

// File: filelist.f
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/sliding_window_median_unit.sv
hdl/swm_checker.sv
sim/tb_sliding_window_median_unit.sv
